/* hdl/kis_pkg.sv */
`default_nettype none

package kis_pkg;

   // table and time sizes
   localparam int MAX_KEYS  = 64;
   localparam int TIME_BITS = 32;
   localparam int FRAC_BITS = 16;

   localparam int IDX_BITS  = $clog2(MAX_KEYS);
   localparam int CNT_BITS  = $clog2(MAX_KEYS + 1);
   localparam int FRAC_W    = FRAC_BITS + 1;
   localparam int KC_BITS   = 7;

   // shared divider: wide enough for the wrap dividend and the fraction quotient
   localparam int DIV_BITS  = (TIME_BITS > FRAC_BITS) ? TIME_BITS : FRAC_BITS + 1;
   localparam int STEP_BITS = $clog2(DIV_BITS);

   // configuration port
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLIP_LENGTH = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KEY_COUNT   = 1'd1;

   // input item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic query_load;
      logic key_write;
      logic wrap_load;
      logic wrap_fix;
      logic scan_first;
      logic scan_step;
      logic frac_load;
      logic div_step;
      logic res_exact;
      logic res_iv;
      logic res_none;
      logic out_load;
   } kis_cmd_type;

   typedef struct packed {
      logic need_wrap;
      logic div_last;
      logic empty;
      logic hit_iv;
      logic hit_ex;
      logic at_last;
   } kis_sts_type;

endpackage

`default_nettype wire

/* hdl/kis_ram.sv */
`default_nettype none

module kis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* hdl/kis_ctrl.sv */
`default_nettype none

module kis_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_kind,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire kis_pkg::kis_sts_type sts,
   output kis_pkg::kis_cmd_type      cmd
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_CHECK = 8'b0000_0010,
      ST_WRAP  = 8'b0000_0100,
      ST_FIX   = 8'b0000_1000,
      ST_PRIME = 8'b0001_0000,
      ST_SCAN  = 8'b0010_0000,
      ST_FRAC  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } kis_state_type;

   kis_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == kis_pkg::KIND_QUERY) begin
                  cmd.query_load = 1'b1;
                  state_in       = ST_CHECK;
               end else begin
                  cmd.key_write = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (sts.need_wrap) begin
               cmd.wrap_load = 1'b1;
               state_in      = ST_WRAP;
            end else begin
               state_in = ST_PRIME;
            end
         end
         ST_WRAP: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.wrap_fix = 1'b1;
            state_in     = ST_PRIME;
         end
         ST_PRIME: begin
            if (sts.empty) begin
               cmd.res_none = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.scan_first = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // interval ending at this key is tested before the exact match on it
            if (sts.hit_iv) begin
               cmd.res_iv    = 1'b1;
               cmd.frac_load = 1'b1;
               state_in      = ST_FRAC;
            end else if (sts.hit_ex) begin
               cmd.res_exact = 1'b1;
               state_in      = ST_DONE;
            end else if (sts.at_last) begin
               cmd.res_none = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_FRAC: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/kis_dp.sv */
`default_nettype none

module kis_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wen,
   input  wire logic [kis_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [kis_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  wire logic [kis_pkg::IDX_BITS-1:0]         req_key_slot,
   input  wire logic [kis_pkg::TIME_BITS-1:0]        req_key_time,
   input  wire logic [kis_pkg::TIME_BITS-1:0]        req_query_time,
   input  wire kis_pkg::kis_cmd_type                 cmd,
   output kis_pkg::kis_sts_type                      sts,
   output logic                                      rsp_found,
   output logic      [kis_pkg::IDX_BITS-1:0]         rsp_idx_before,
   output logic      [kis_pkg::IDX_BITS-1:0]         rsp_idx_start,
   output logic      [kis_pkg::IDX_BITS-1:0]         rsp_idx_end,
   output logic      [kis_pkg::IDX_BITS-1:0]         rsp_idx_after,
   output logic      [kis_pkg::FRAC_W-1:0]           rsp_fraction
);

   localparam int TB = kis_pkg::TIME_BITS;
   localparam int IB = kis_pkg::IDX_BITS;
   localparam int CB = kis_pkg::CNT_BITS;
   localparam int DB = kis_pkg::DIV_BITS;
   localparam int SB = kis_pkg::STEP_BITS;
   localparam int FW = kis_pkg::FRAC_W;

   // configuration
   logic [TB-1:0]                clip_length_ff;
   logic [kis_pkg::KC_BITS-1:0]  key_count_ff;
   logic [CB-1:0]                n_keys;

   // query time and scan
   logic [TB-1:0] t_ff;
   logic [TB-1:0] prev_ff;
   logic [IB-1:0] idx_ff;
   logic [TB-1:0] rd_data;
   logic [IB-1:0] rd_addr;
   logic          rd_en;
   logic          wr_en;

   // shared restoring divider
   logic [TB:0]   rem_ff, rem_in;
   logic [DB-1:0] sh_ff, sh_in;
   logic [TB:0]   den_ff;
   logic [SB-1:0] cnt_ff;
   logic          first_ff;
   logic [TB:0]   cand;
   logic          ge;

   // result under construction
   logic          found_ff, iv_ff;
   logic [IB-1:0] before_ff, start_ff, end_ff, after_ff;
   logic [IB-1:0] iv_start;
   logic [CB-1:0] last_idx;

   // output register
   logic          rsp_found_ff;
   logic [IB-1:0] rsp_before_ff, rsp_start_ff, rsp_end_ff, rsp_after_ff;
   logic [FW-1:0] rsp_fraction_ff;

   always_comb begin
      if (CB'(key_count_ff) > CB'(kis_pkg::MAX_KEYS)) begin
         n_keys = CB'(kis_pkg::MAX_KEYS);
      end else begin
         n_keys = CB'(key_count_ff);
      end
   end

   assign last_idx = n_keys - CB'(1);

   // key table
   assign wr_en   = cmd.key_write && (CB'(req_key_slot) < CB'(kis_pkg::MAX_KEYS));
   assign rd_en   = cmd.scan_first || cmd.scan_step;
   assign rd_addr = cmd.scan_first ? '0 : idx_ff + IB'(1);

   kis_ram #(
      .WIDTH (TB),
      .DEPTH (kis_pkg::MAX_KEYS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_key_slot),
      .wr_data (req_key_time),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // status toward the controller
   always_comb begin
      sts.need_wrap = (clip_length_ff != '0) && (t_ff > clip_length_ff);
      sts.div_last  = (cnt_ff == '0);
      sts.empty     = (n_keys == '0);
      sts.hit_iv    = (idx_ff != '0) && (prev_ff < t_ff) && (t_ff <= rd_data);
      sts.hit_ex    = (t_ff == rd_data);
      sts.at_last   = (CB'(idx_ff) == last_idx);
   end

   // one quotient bit per step; the fraction's first step compares unshifted
   always_comb begin
      if (first_ff) begin
         cand = rem_ff;
      end else begin
         cand = {rem_ff[TB-1:0], sh_ff[DB-1]};
      end
      ge     = (cand >= den_ff);
      rem_in = ge ? (cand - den_ff) : cand;
      sh_in  = {sh_ff[DB-2:0], ge};
   end

   assign iv_start = idx_ff - IB'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_length_ff <= '0;
         key_count_ff   <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            kis_pkg::CSR_CLIP_LENGTH: clip_length_ff <= csr_wdata[TB-1:0];
            kis_pkg::CSR_KEY_COUNT:   key_count_ff   <= csr_wdata[kis_pkg::KC_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.query_load) begin
         t_ff <= req_query_time;
      end else if (cmd.wrap_fix) begin
         t_ff <= rem_ff[TB-1:0] + TB'(1);
      end

      if (cmd.scan_first) begin
         idx_ff <= '0;
      end else if (cmd.scan_step) begin
         idx_ff  <= idx_ff + IB'(1);
         prev_ff <= rd_data;
      end

      if (cmd.wrap_load) begin
         rem_ff   <= '0;
         sh_ff    <= DB'(t_ff - TB'(1));
         den_ff   <= {1'b0, clip_length_ff};
         cnt_ff   <= SB'(DB - 1);
         first_ff <= 1'b0;
      end else if (cmd.frac_load) begin
         rem_ff   <= {1'b0, t_ff - prev_ff};
         sh_ff    <= '0;
         den_ff   <= {1'b0, rd_data - prev_ff};
         cnt_ff   <= SB'(kis_pkg::FRAC_BITS);
         first_ff <= 1'b1;
      end else if (cmd.div_step) begin
         rem_ff   <= rem_in;
         sh_ff    <= sh_in;
         cnt_ff   <= cnt_ff - SB'(1);
         first_ff <= 1'b0;
      end

      if (cmd.res_exact) begin
         found_ff  <= 1'b1;
         iv_ff     <= 1'b0;
         before_ff <= idx_ff;
         start_ff  <= idx_ff;
         end_ff    <= idx_ff;
         after_ff  <= idx_ff;
      end else if (cmd.res_iv) begin
         found_ff  <= 1'b1;
         iv_ff     <= 1'b1;
         before_ff <= (iv_start != '0) ? iv_start - IB'(1) : '0;
         start_ff  <= iv_start;
         end_ff    <= idx_ff;
         after_ff  <= (CB'(idx_ff) != last_idx) ? idx_ff + IB'(1) : idx_ff;
      end else if (cmd.res_none) begin
         found_ff  <= 1'b0;
         iv_ff     <= 1'b0;
         before_ff <= '0;
         start_ff  <= '0;
         end_ff    <= '0;
         after_ff  <= '0;
      end

      if (cmd.out_load) begin
         rsp_found_ff    <= found_ff;
         rsp_before_ff   <= before_ff;
         rsp_start_ff    <= start_ff;
         rsp_end_ff      <= end_ff;
         rsp_after_ff    <= after_ff;
         rsp_fraction_ff <= iv_ff ? sh_ff[FW-1:0] : '0;
      end
   end

   assign rsp_found      = rsp_found_ff;
   assign rsp_idx_before = rsp_before_ff;
   assign rsp_idx_start  = rsp_start_ff;
   assign rsp_idx_end    = rsp_end_ff;
   assign rsp_idx_after  = rsp_after_ff;
   assign rsp_fraction   = rsp_fraction_ff;

endmodule

`default_nettype wire

/* hdl/keyframe_interval_select.sv */
// channel | ports                                      | transfer when
// --------+--------------------------------------------+-------------------------
// req     | req_valid/req_stall, kind, slot, key/query | req_valid && !req_stall
// rsp     | rsp_valid/rsp_stall, found, 4 idx, fraction| rsp_valid && !rsp_stall
// csr     | csr_wen, csr_index, csr_wdata              | csr_wen
//
// a load is written from idle without leaving it; a query steps through check, wrap
// and fix only with wrapping (one bit a cycle in the shared restoring divider), then
// prime, scan over the keys (one table read a cycle, up to 64), fraction when an
// interval hits (same divider), and done; one query in flight at a time
// reset is synchronous; it clears control and configuration, the key table is not
// cleared and must be loaded before a query reads it
// a finished result sits in the output register, so the next item is taken while
// rsp is stalled; a new result waits in its last state until the register frees
`default_nettype none

module keyframe_interval_select (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration
   input  wire logic                              csr_wen,
   input  wire logic [kis_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [kis_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   // input items
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_kind,
   input  wire logic [kis_pkg::IDX_BITS-1:0]      req_key_slot,
   input  wire logic [kis_pkg::TIME_BITS-1:0]     req_key_time,
   input  wire logic [kis_pkg::TIME_BITS-1:0]     req_query_time,
   // results
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_found,
   output logic      [kis_pkg::IDX_BITS-1:0]      rsp_idx_before,
   output logic      [kis_pkg::IDX_BITS-1:0]      rsp_idx_start,
   output logic      [kis_pkg::IDX_BITS-1:0]      rsp_idx_end,
   output logic      [kis_pkg::IDX_BITS-1:0]      rsp_idx_after,
   output logic      [kis_pkg::FRAC_W-1:0]        rsp_fraction
);

   // commands from the sequencer, status back from the datapath
   kis_pkg::kis_cmd_type cmd;
   kis_pkg::kis_sts_type sts;

   // sequencer: wrap, scan and fraction phases plus output handoff
   kis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: key table, shared divider, scan compare and output register
   kis_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_key_slot   (req_key_slot),
      .req_key_time   (req_key_time),
      .req_query_time (req_query_time),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_found      (rsp_found),
      .rsp_idx_before (rsp_idx_before),
      .rsp_idx_start  (rsp_idx_start),
      .rsp_idx_end    (rsp_idx_end),
      .rsp_idx_after  (rsp_idx_after),
      .rsp_fraction   (rsp_fraction)
   );

endmodule

`default_nettype wire

/* hdl/kis_checker.sv */
`default_nettype none

module kis_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire logic                              rsp_found,
   input  wire logic [kis_pkg::IDX_BITS-1:0]      rsp_idx_before,
   input  wire logic [kis_pkg::IDX_BITS-1:0]      rsp_idx_start,
   input  wire logic [kis_pkg::IDX_BITS-1:0]      rsp_idx_end,
   input  wire logic [kis_pkg::IDX_BITS-1:0]      rsp_idx_after,
   input  wire logic [kis_pkg::FRAC_W-1:0]        rsp_fraction
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_idx_start) && $stable(rsp_idx_end) && $stable(rsp_fraction))
      else $error("stalled result changed");

   // a miss reports all zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_idx_before == '0 && rsp_idx_start == '0
         && rsp_idx_end == '0 && rsp_idx_after == '0 && rsp_fraction == '0)
      else $error("miss with nonzero fields");

   // fraction never exceeds one
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fraction[kis_pkg::FRAC_BITS]
         |-> rsp_fraction[kis_pkg::FRAC_BITS-1:0] == '0)
      else $error("fraction above one");

   // indices are ordered and the interval spans at most one key step
   a_idx_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_idx_before <= rsp_idx_start
         && rsp_idx_end <= rsp_idx_after
         && (rsp_idx_end == rsp_idx_start
             || rsp_idx_end == rsp_idx_start + kis_pkg::IDX_BITS'(1)))
      else $error("result indices out of order");

endmodule

bind keyframe_interval_select kis_checker u_kis_checker (.*);

`default_nettype wire
